// File: rtl/pgn_lex_pkg.sv
// shared token result types and code constants for the pgn token lexer
package pgn_lex_pkg;

  // token kinds
  localparam logic [3:0] KIND_END      = 4'd0;
  localparam logic [3:0] KIND_STRING   = 4'd1;
  localparam logic [3:0] KIND_SYMBOL   = 4'd2;
  localparam logic [3:0] KIND_PERIOD   = 4'd3;
  localparam logic [3:0] KIND_ASTERISK = 4'd4;
  localparam logic [3:0] KIND_LBRACKET = 4'd5;
  localparam logic [3:0] KIND_RBRACKET = 4'd6;
  localparam logic [3:0] KIND_LPAREN   = 4'd7;
  localparam logic [3:0] KIND_RPAREN   = 4'd8;
  localparam logic [3:0] KIND_LANGLE   = 4'd9;
  localparam logic [3:0] KIND_RANGLE   = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_NONPRINT = 2'd2;
  localparam logic [1:0] ERR_SPAN     = 2'd3;

  // span limit after reset
  localparam logic [15:0] SPAN_LIMIT_RESET = 16'd255;

  // one result beat
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  err;
    logic        last;
  } token_t;

  // results produced by one byte, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

endpackage

// File: rtl/pgn_lex_core.sv
// byte classification, lexer mode state and position tracking
module pgn_lex_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         text_byte,
  input  logic [15:0]        span_limit,
  output pgn_lex_pkg::push_t push
);
  import pgn_lex_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int CW = (PB > 16) ? PB : 16;
  localparam logic [PB-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SYMBOL,
    MODE_STRING,
    MODE_ERROR
  } mode_t;

  mode_t         mode, mode_next;
  logic [PB-1:0] position, position_next;
  logic [PB-1:0] origin, origin_next;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic continues_symbol(input logic [7:0] c);
    return is_alnum(c) || c == "_" || c == "+" || c == "#" || c == "=" ||
           c == "," || c == "-" || c == "/";
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      ".":     k = KIND_PERIOD;
      "*":     k = KIND_ASTERISK;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "<":     k = KIND_LANGLE;
      ">":     k = KIND_RANGLE;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic token_t make_tok(input logic [3:0] kind, input logic [PB-1:0] start,
                                      input logic [PB-1:0] length, input logic [1:0] err);
    token_t t;
    t.kind   = kind;
    t.start  = 16'(start);
    t.length = 16'(length);
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

  // outcome of lexing the byte from idle
  logic       id_emit, id_open, id_pos_reset;
  mode_t      id_mode;
  token_t     id_tok;
  logic [3:0] pkind;

  always_comb begin
    pkind        = punct_kind(text_byte);
    id_emit      = 1'b0;
    id_open      = 1'b0;
    id_pos_reset = 1'b0;
    id_mode      = MODE_IDLE;
    id_tok       = make_tok(KIND_END, position, '0, ERR_NONE);
    if (text_byte == CH_SPACE || text_byte == CH_LF || text_byte == CH_TAB) begin
      id_mode = MODE_IDLE;
    end else if (is_alnum(text_byte)) begin
      id_open = 1'b1;
      id_mode = MODE_SYMBOL;
    end else if (text_byte == CH_QUOTE) begin
      id_open = 1'b1;
      id_mode = MODE_STRING;
    end else if (text_byte == CH_NUL) begin
      id_emit      = 1'b1;
      id_pos_reset = 1'b1;
      id_tok       = make_tok(KIND_END, position, PB'(1), ERR_NONE);
    end else if (pkind != KIND_END) begin
      id_emit = 1'b1;
      id_tok  = make_tok(pkind, position, PB'(1), ERR_NONE);
    end else begin
      id_emit = 1'b1;
      id_mode = MODE_ERROR;
      id_tok  = make_tok(KIND_END, position, '0, ERR_UNKNOWN);
    end
  end

  // string span and symbol length, both saturating
  logic          ahead;
  logic [PB:0]   span_wide;
  logic [PB-1:0] span, sym_len;
  logic          span_hit;

  always_comb begin
    ahead     = position >= origin;
    span_wide = ahead ? ({1'b0, position} - {1'b0, origin} + (PB+1)'(1)) : (PB+1)'(1);
    span      = span_wide[PB] ? POS_MAX : span_wide[PB-1:0];
    sym_len   = ahead ? (position - origin) : '0;
    span_hit  = CW'(span) >= CW'(span_limit);
  end

  logic       pos_reset;
  logic [1:0] cnt;
  token_t     t0, t1;

  always_comb begin
    mode_next   = mode;
    origin_next = origin;
    pos_reset   = 1'b0;
    cnt         = 2'd0;
    t0          = id_tok;
    t1          = id_tok;
    unique case (mode)
      MODE_IDLE: begin
        mode_next = id_mode;
        if (id_open) origin_next = position;
        pos_reset = id_pos_reset;
        cnt       = {1'b0, id_emit};
      end
      MODE_SYMBOL: begin
        if (!continues_symbol(text_byte)) begin
          // close the symbol, then lex the same byte from idle
          t0        = make_tok(KIND_SYMBOL, origin, sym_len, ERR_NONE);
          t1        = id_tok;
          mode_next = id_mode;
          if (id_open) origin_next = position;
          pos_reset = id_pos_reset;
          cnt       = id_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_STRING: begin
        if (text_byte < PRINT_LO || text_byte > PRINT_HI) begin
          mode_next = MODE_ERROR;
          t0        = make_tok(KIND_END, position, '0, ERR_NONPRINT);
          cnt       = 2'd1;
        end else if (span_hit) begin
          mode_next = MODE_ERROR;
          t0        = make_tok(KIND_END, position, '0, ERR_SPAN);
          cnt       = 2'd1;
        end else if (text_byte == CH_QUOTE) begin
          mode_next = MODE_IDLE;
          t0        = make_tok(KIND_STRING, origin, span, ERR_NONE);
          cnt       = 2'd1;
        end
      end
      MODE_ERROR: begin
        cnt = 2'd0;
      end
      default: begin
        cnt = 2'd0;
      end
    endcase
    if (cnt == 2'd1) t0.last = 1'b1;
    if (cnt == 2'd2) t1.last = 1'b1;

    if (mode_next == MODE_ERROR)  position_next = position;
    else if (pos_reset)           position_next = '0;
    else if (position != POS_MAX) position_next = position + PB'(1);
    else                          position_next = position;
  end

  always_comb begin
    push.count  = fire ? cnt : 2'd0;
    push.first  = t0;
    push.second = t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      position <= '0;
      origin   <= '0;
    end else if (fire) begin
      mode     <= mode_next;
      position <= position_next;
      origin   <= origin_next;
    end
  end

endmodule

// File: rtl/pgn_lex_fifo.sv
// four-entry result queue, up to two writes and one read per cycle while not stalled
module pgn_lex_fifo (
  input  logic                clk,
  input  logic                rst,
  input  pgn_lex_pkg::push_t  push,
  output logic                room,
  output logic                valid,
  input  logic                stall,
  output pgn_lex_pkg::token_t head
);
  import pgn_lex_pkg::*;

  token_t     slots [4];
  logic [1:0] rd, wr;
  logic [2:0] count;
  logic       pop;

  assign room  = count <= 3'd2;
  assign valid = count != 3'd0;
  assign head  = slots[rd];
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots[wr] <= push.first;
    if (push.count == 2'd2) slots[wr + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + push.count;
      rd    <= rd + {1'b0, pop};
      count <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

endmodule

// File: rtl/pgn_token_lexer_unit.sv
// top level of the pgn token lexer: input register, lexer core and result queue
//
// text channel: one byte per beat on text_byte, taken at a clock edge where
// text_valid is high and text_stall is low. a zero byte ends the text.
// token channel: one result per beat (token_kind, token_start, token_length,
// error_code, last_of_run), taken where token_valid is high and token_stall low.
// one byte gives zero, one or two results; last_of_run marks the final one.
// config channel: cfg_data is written to the string span limit where
// cfg_valid and cfg_ready are high; cfg_ready is always high.
// a result reaches the token side through the input register and then the result queue.
// throughput: one byte per cycle while the token side keeps up; the rate is
// set by the single token beat per cycle the four-entry result queue drains.
// a byte giving two results holds the input only if the queue fills up.
// when the receiver stalls, results wait in the queue and text_stall rises
// once fewer than two entries are free, holding the byte in the input register.
// reset (rst, synchronous): mode idle, position zero, queue empty, span limit
// back to 255. after an error result the lexer ignores bytes until reset.
module pgn_token_lexer_unit #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // text channel
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  // token channel
  output logic        token_valid,
  input  logic        token_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [1:0]  error_code,
  output logic        last_of_run,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import pgn_lex_pkg::*;

  logic [15:0] span_limit;

  // input register
  logic        in_full;
  logic [7:0]  in_byte;
  logic        room;
  logic        fire;
  logic        take;

  push_t       push;
  token_t      head;

  // the held byte is lexed once the queue can take two results
  assign fire       = in_full && room;
  assign text_stall = in_full && !room;
  assign take       = text_valid && !text_stall;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      span_limit <= SPAN_LIMIT_RESET;
    end else begin
      if (take)      in_full <= 1'b1;
      else if (fire) in_full <= 1'b0;
      if (cfg_valid && cfg_ready) span_limit <= cfg_data;
    end
  end

  // byte payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) in_byte <= text_byte;
  end

  pgn_lex_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .text_byte  (in_byte),
    .span_limit (span_limit),
    .push       (push)
  );

  pgn_lex_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (token_valid),
    .stall (token_stall),
    .head  (head)
  );

  // result fields straight from the queue head
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign error_code   = head.err;
  assign last_of_run  = head.last;

endmodule
